@@ hdl/sfva_pkg.sv @@
// ----------------------------------------------------------------------------
// sfva_pkg
// Shared types, codes and helpers of the string fret voice allocator.
// ----------------------------------------------------------------------------
package sfva_pkg;

	localparam int SFVA_NUM_STRINGS = 6;
	localparam int SFVA_BATCH_DEPTH = 8;
	localparam int SFVA_CMDQ_DEPTH  = 4;
	localparam int SFVA_OUTQ_DEPTH  = 4;
	localparam int SFVA_NUM_REGS    = 7;

	localparam logic [2:0] REG_MAX_FRET = 3'd6;

	localparam logic [1:0] FN_NOTE_ON  = 2'd0;
	localparam logic [1:0] FN_NOTE_OFF = 2'd1;

	typedef enum logic [2:0] {
		ACT_PLAY    = 3'd0,
		ACT_KILL    = 3'd1,
		ACT_RELEASE = 3'd2,
		ACT_UNPLAY  = 3'd3,
		ACT_OVFL    = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		OP_NONE    = 2'd0,
		OP_APPEND  = 2'd1,
		OP_OVFL    = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef struct packed {
		logic       flush;
		op_t        op;
		logic [6:0] note;
		logic [6:0] vel;
	} cmd_t;

	typedef struct packed {
		act_t       action;
		logic [2:0] str;
		logic [6:0] note;
		logic [6:0] vel;
		logic [5:0] fret;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [SFVA_NUM_STRINGS-1:0][6:0] open;
		logic [5:0]                       max_fret;
	} cfg_t;

	localparam logic [6:0] TUNING_RESET [SFVA_NUM_STRINGS] = '{
		7'd40, 7'd45, 7'd50, 7'd55, 7'd59, 7'd64
	};
	localparam logic [5:0] MAX_FRET_RESET = 6'd24;

	function automatic logic fits(input logic [6:0] open, input logic [6:0] note,
		input logic [5:0] maxf);
		logic [7:0] d;
		d = {1'b0, note} - {1'b0, open};
		return !d[7] && (d[6:0] <= {1'b0, maxf});
	endfunction

	function automatic logic [2:0] cand_count(input cfg_t cfg, input logic [6:0] note);
		logic [2:0] c;
		c = '0;
		for (int s = 0; s < SFVA_NUM_STRINGS; s++) begin
			c = c + {2'b00, fits(cfg.open[s], note, cfg.max_fret)};
		end
		return c;
	endfunction

endpackage

@@ hdl/sfva_fifo.sv @@
// ----------------------------------------------------------------------------
// sfva_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module sfva_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ hdl/sfva_front.sv @@
// ----------------------------------------------------------------------------
// sfva_front
// Classifies incoming MIDI events into commands for the back end.
// ----------------------------------------------------------------------------
module sfva_front #(
	parameter int BATCH_DEPTH = sfva_pkg::SFVA_BATCH_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    func,
	input  logic [6:0]    note,
	input  logic [6:0]    velocity,
	input  logic [15:0]   sample_pos,
	output logic          cmd_push,
	output sfva_pkg::cmd_t cmd,
	input  logic          cmd_full
);
	import sfva_pkg::*;

	localparam int CW = $clog2(BATCH_DEPTH + 1);

	logic [15:0]   pos_q;
	logic          open_q;
	logic [CW-1:0] cnt_q;
	logic          is_on, do_flush;
	logic [CW-1:0] base_cnt;

	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full;
	assign is_on    = (func == FN_NOTE_ON) && (velocity != '0);
	assign do_flush = is_on ? (open_q && (sample_pos != pos_q)) : 1'b1;
	assign base_cnt = do_flush ? '0 : cnt_q;

	always_comb begin
		cmd.flush = do_flush;
		cmd.note  = note;
		cmd.vel   = velocity;
		if (is_on) begin
			cmd.op = (base_cnt < CW'(BATCH_DEPTH)) ? OP_APPEND : OP_OVFL;
		end else if (func == FN_NOTE_ON || func == FN_NOTE_OFF) begin
			cmd.op = OP_RELEASE;
		end else begin
			cmd.op = OP_NONE;
		end
	end

	// mirror of the back end batch fill, kept in command order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			open_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd_push) begin
			if (is_on) begin
				pos_q  <= sample_pos;
				open_q <= 1'b1;
				cnt_q  <= (base_cnt < CW'(BATCH_DEPTH)) ? base_cnt + CW'(1) : base_cnt;
			end else begin
				pos_q  <= '0;
				open_q <= 1'b0;
				cnt_q  <= '0;
			end
		end
	end

endmodule

@@ hdl/sfva_back.sv @@
// ----------------------------------------------------------------------------
// sfva_back
// Executes commands: batch fill, chord sort, string allocation, overflow reports and release.
// ----------------------------------------------------------------------------
module sfva_back #(
	parameter int BATCH_DEPTH = sfva_pkg::SFVA_BATCH_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sfva_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  sfva_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           out_full,
	output logic           out_push,
	output sfva_pkg::res_t out_data
);
	import sfva_pkg::*;

	localparam int IW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
	localparam int CW = $clog2(BATCH_DEPTH + 1);
	localparam int NS = SFVA_NUM_STRINGS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SORT, ST_ALLOC, ST_KPLAY, ST_OP, ST_DONE
	} state_t;

	state_t        state_q;
	cmd_t          cur_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic [NS-1:0] used_q;
	logic [2:0]    pick_q;
	logic [NS-1:0] ringing_q;
	logic [6:0]    held_note_q [NS];
	logic          pend_valid_q;
	res_t          pend_q;

	logic [6:0] batch_note_q [BATCH_DEPTH];
	logic [6:0] batch_vel_q  [BATCH_DEPTH];
	logic [6:0] srt_note_q   [BATCH_DEPTH];
	logic [6:0] srt_vel_q    [BATCH_DEPTH];
	logic [2:0] srt_ct_q     [BATCH_DEPTH];

	logic             emit_ok, emit_en, last_step, batch_wr;
	res_t             emit_res;
	logic [6:0]       in_note, in_vel, cur_note, cur_vel;
	logic [2:0]       in_ct;
	logic [BATCH_DEPTH-1:0] pass;
	logic             found, rel_found;
	logic [2:0]       pick, rel_str;
	logic [6:0]       fret_full;
	logic [2:0]       play_str;

	assign emit_ok   = !pend_valid_q || !out_full;
	assign last_step = (CW'(idx_q) + CW'(1) == cnt_q);
	assign in_note   = batch_note_q[idx_q];
	assign in_vel    = batch_vel_q[idx_q];
	assign in_ct     = cand_count(cfg, in_note);
	assign cur_note  = srt_note_q[idx_q];
	assign cur_vel   = srt_vel_q[idx_q];
	assign play_str  = (state_q == ST_KPLAY) ? pick_q : pick;
	assign fret_full = cur_note - cfg.open[play_str];

	// entries that the new note moves past
	always_comb begin
		for (int j = 0; j < BATCH_DEPTH; j++) begin
			pass[j] = (j < int'(idx_q)) && ((srt_ct_q[j] > in_ct) ||
				((srt_ct_q[j] == in_ct) && (srt_note_q[j] < in_note)));
		end
	end

	// highest free string that fits
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int s = 0; s < NS; s++) begin
			if (!used_q[s] && fits(cfg.open[s], cur_note, cfg.max_fret)) begin
				found = 1'b1;
				pick  = 3'(s);
			end
		end
	end

	// lowest ringing string holding the note
	always_comb begin
		rel_found = 1'b0;
		rel_str   = '0;
		for (int s = NS - 1; s >= 0; s--) begin
			if (ringing_q[s] && held_note_q[s] == cur_q.note) begin
				rel_found = 1'b1;
				rel_str   = 3'(s);
			end
		end
	end

	always_comb begin
		emit_en  = 1'b0;
		emit_res = '{action: ACT_PLAY, str: '0, note: '0, vel: '0, fret: '0, last: 1'b0};
		cmd_pop  = 1'b0;
		batch_wr = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd_pop = cmd_valid;
			ST_ALLOC: begin
				if (emit_ok) begin
					emit_en = 1'b1;
					if (!found) begin
						emit_res.action = ACT_UNPLAY;
						emit_res.note   = cur_note;
					end else if (ringing_q[pick]) begin
						emit_res.action = ACT_KILL;
						emit_res.str    = pick;
						emit_res.note   = held_note_q[pick];
					end else begin
						emit_res.str  = pick;
						emit_res.note = cur_note;
						emit_res.vel  = cur_vel;
						emit_res.fret = fret_full[5:0];
					end
				end
			end
			ST_KPLAY: begin
				if (emit_ok) begin
					emit_en       = 1'b1;
					emit_res.str  = pick_q;
					emit_res.note = cur_note;
					emit_res.vel  = cur_vel;
					emit_res.fret = fret_full[5:0];
				end
			end
			ST_OP: begin
				unique case (cur_q.op)
					OP_APPEND: batch_wr = 1'b1;
					OP_OVFL: begin
						emit_en         = emit_ok;
						emit_res.action = ACT_OVFL;
						emit_res.note   = cur_q.note;
					end
					OP_RELEASE: begin
						emit_en         = emit_ok && rel_found;
						emit_res.action = ACT_RELEASE;
						emit_res.str    = rel_str;
						emit_res.note   = cur_q.note;
					end
					OP_NONE: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		out_push = 1'b0;
		out_data = pend_q;
		if (emit_en && pend_valid_q) begin
			out_push = 1'b1;
		end else if (state_q == ST_DONE && pend_valid_q && !out_full) begin
			out_push      = 1'b1;
			out_data.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (batch_wr) begin
			batch_note_q[cnt_q[IW-1:0]] <= cur_q.note;
			batch_vel_q[cnt_q[IW-1:0]]  <= cur_q.vel;
		end
		if (state_q == ST_SORT) begin
			for (int j = 0; j < BATCH_DEPTH; j++) begin
				if (j <= int'(idx_q) && !(j < int'(idx_q) && !pass[j])) begin
					if (j == 0 || !pass[j-1]) begin
						srt_note_q[j] <= in_note;
						srt_vel_q[j]  <= in_vel;
						srt_ct_q[j]   <= in_ct;
					end else begin
						srt_note_q[j] <= srt_note_q[j-1];
						srt_vel_q[j]  <= srt_vel_q[j-1];
						srt_ct_q[j]   <= srt_ct_q[j-1];
					end
				end
			end
		end
		if (emit_en) begin
			pend_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			used_q       <= '0;
			pick_q       <= '0;
			ringing_q    <= '0;
			pend_valid_q <= 1'b0;
			for (int s = 0; s < NS; s++) begin
				held_note_q[s] <= '0;
			end
		end else begin
			if (emit_en) begin
				pend_valid_q <= 1'b1;
			end else if (out_push) begin
				pend_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cur_q   <= cmd;
						idx_q   <= '0;
						state_q <= (cmd.flush && cnt_q != '0) ? ST_SORT : ST_OP;
					end
				end
				ST_SORT: begin
					if (last_step) begin
						idx_q   <= '0;
						used_q  <= '0;
						state_q <= ST_ALLOC;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_ALLOC, ST_KPLAY: begin
					if (emit_ok) begin
						if (state_q == ST_ALLOC && found && ringing_q[pick]) begin
							pick_q  <= pick;
							state_q <= ST_KPLAY;
						end else begin
							if (state_q == ST_KPLAY || found) begin
								used_q[play_str]      <= 1'b1;
								ringing_q[play_str]   <= 1'b1;
								held_note_q[play_str] <= cur_note;
							end
							if (last_step) begin
								cnt_q   <= '0;
								state_q <= ST_OP;
							end else begin
								idx_q   <= idx_q + IW'(1);
								state_q <= ST_ALLOC;
							end
						end
					end
				end
				ST_OP: begin
					unique case (cur_q.op)
						OP_APPEND: begin
							cnt_q   <= cnt_q + CW'(1);
							state_q <= ST_DONE;
						end
						OP_OVFL: begin
							if (emit_ok) begin
								state_q <= ST_DONE;
							end
						end
						OP_RELEASE: begin
							if (!rel_found) begin
								state_q <= ST_DONE;
							end else if (emit_ok) begin
								ringing_q[rel_str]   <= 1'b0;
								held_note_q[rel_str] <= '0;
								state_q              <= ST_DONE;
							end
						end
						OP_NONE: state_q <= ST_DONE;
					endcase
				end
				ST_DONE: begin
					if (!pend_valid_q || !out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full) else $error("result pushed into full queue");
	a_sort_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT || state_q == ST_ALLOC) |-> (CW'(idx_q) < cnt_q))
		else $error("chord index beyond batch fill");
	a_kill_ringing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KPLAY) |-> ringing_q[pick_q])
		else $error("kill issued on silent string");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !pend_valid_q) |=> (state_q == ST_IDLE))
		else $error("command did not retire");
`endif

endmodule

@@ hdl/string_fret_voice_allocator_core.sv @@
// ----------------------------------------------------------------------------
// string_fret_voice_allocator_core
// Allocates MIDI note events to six tuned strings, chord by chord.
// ----------------------------------------------------------------------------
// channel   | handshake                      | payload
// ----------+--------------------------------+-----------------------------------
// events    | push / full                    | func note velocity sample_pos
// results   | empty / pop                    | action string_index note_out
//           |                                | velocity_out fret last
// config    | psel penable pwrite pready     | paddr pwdata prdata
//
// Events enter a 4-entry command queue at one per cycle while it is not
// full; on a flush the command sequencer sorts and allocates the pending
// chord, with a kill before each play on a ringing string, then runs the event.
// Results leave through a 4-entry queue; a full result queue stalls the
// sequencer, a full command queue raises full.
// Reset clears strings, batch state and registers to their defaults at once.
// ----------------------------------------------------------------------------
module string_fret_voice_allocator_core #(
	parameter int BATCH_DEPTH = sfva_pkg::SFVA_BATCH_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [6:0]  note,
	input  logic [6:0]  velocity,
	input  logic [15:0] sample_pos,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  action,
	output logic [2:0]  string_index,
	output logic [6:0]  note_out,
	output logic [6:0]  velocity_out,
	output logic [5:0]  fret,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sfva_pkg::*;

	cfg_t       cfg_q;
	cmd_t       f_cmd, q_cmd;
	logic       f_push, cq_full, cq_empty, cq_pop;
	logic       o_push, o_full;
	res_t       o_data, o_head;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_MAX_FRET) begin
			prdata[5:0] = cfg_q.max_fret;
		end else if (reg_idx < REG_MAX_FRET) begin
			prdata[6:0] = cfg_q.open[reg_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SFVA_NUM_STRINGS; s++) begin
				cfg_q.open[s] <= TUNING_RESET[s];
			end
			cfg_q.max_fret <= MAX_FRET_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_idx == REG_MAX_FRET) begin
				cfg_q.max_fret <= pwdata[5:0];
			end else if (reg_idx < REG_MAX_FRET) begin
				cfg_q.open[reg_idx] <= pwdata[6:0];
			end
		end
	end

	sfva_front #(.BATCH_DEPTH(BATCH_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.note       (note),
		.velocity   (velocity),
		.sample_pos (sample_pos),
		.cmd_push   (f_push),
		.cmd        (f_cmd),
		.cmd_full   (cq_full)
	);

	sfva_fifo #(.W($bits(cmd_t)), .DEPTH(SFVA_CMDQ_DEPTH)) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_cmd),
		.full   (cq_full),
		.pop    (cq_pop),
		.dout   (q_cmd),
		.empty  (cq_empty)
	);

	sfva_back #(.BATCH_DEPTH(BATCH_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (!cq_empty),
		.cmd       (q_cmd),
		.cmd_pop   (cq_pop),
		.out_full  (o_full),
		.out_push  (o_push),
		.out_data  (o_data)
	);

	sfva_fifo #(.W($bits(res_t)), .DEPTH(SFVA_OUTQ_DEPTH)) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (o_push),
		.din    (o_data),
		.full   (o_full),
		.pop    (pop),
		.dout   (o_head),
		.empty  (empty)
	);

	assign action       = o_head.action;
	assign string_index = o_head.str;
	assign note_out     = o_head.note;
	assign velocity_out = o_head.vel;
	assign fret         = o_head.fret;
	assign last         = o_head.last;

endmodule

@@ tb/string_fret_voice_allocator_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_fret_voice_allocator_core_test
// Drives MIDI events through the voice allocator under several tunings and
// fret limits, predicts every play, kill, release and error transaction, and
// checks the result queue in order under random back-pressure.
// ----------------------------------------------------------------------------
module string_fret_voice_allocator_core_test;
	import sfva_pkg::*;

	localparam logic [1:0] FN_OTHER = 2'd2;
	localparam logic [1:0] FN_EOB   = 2'd3;
	localparam int NSTR  = SFVA_NUM_STRINGS;
	localparam int DEPTH = SFVA_BATCH_DEPTH;

	class voicing_tracker;
		logic [6:0] open_note [NSTR];
		logic [5:0] max_fret;
		bit         ringing [NSTR];
		logic [6:0] held_note [NSTR];
		logic [6:0] chord_note [DEPTH];
		logic [6:0] chord_vel [DEPTH];
		int         chord_count;
		logic [15:0] chord_pos;
		bit         chord_open;
		res_t       pending [$];
		int         errors;
		int         checked;

		function new();
			for (int s = 0; s < NSTR; s++) begin
				open_note[s] = TUNING_RESET[s];
				ringing[s] = 0;
				held_note[s] = '0;
			end
			max_fret = MAX_FRET_RESET;
			chord_count = 0;
			chord_pos = '0;
			chord_open = 0;
			errors = 0;
			checked = 0;
		endfunction

		function bit playable(int s, int n);
			return n >= open_note[s] && (n - open_note[s]) <= max_fret;
		endfunction

		function void add(act_t a, int s, int n, int v, int f);
			res_t r;
			r.action = a;
			r.str = s[2:0];
			r.note = n[6:0];
			r.vel = v[6:0];
			r.fret = f[5:0];
			r.last = 1'b0;
			pending.insert(pending.size(), r);
		endfunction

		function void allocate_chord();
			int nt [DEPTH];
			int vl [DEPTH];
			int ct [DEPTH];
			int j, c, pick;
			bit used [NSTR];
			for (int s = 0; s < NSTR; s++) used[s] = 0;
			// order by string count, fewest first, then by note, highest first
			for (int i = 0; i < chord_count; i++) begin
				c = 0;
				for (int s = 0; s < NSTR; s++) c += playable(s, chord_note[i]);
				j = i;
				while (j > 0 && (ct[j-1] > c || (ct[j-1] == c && nt[j-1] < chord_note[i]))) begin
					nt[j] = nt[j-1];
					vl[j] = vl[j-1];
					ct[j] = ct[j-1];
					j--;
				end
				nt[j] = chord_note[i];
				vl[j] = chord_vel[i];
				ct[j] = c;
			end
			for (int i = 0; i < chord_count; i++) begin
				pick = -1;
				for (int s = NSTR - 1; s >= 0; s--) begin
					if (!used[s] && playable(s, nt[i])) begin
						pick = s;
						break;
					end
				end
				if (pick < 0) begin
					add(ACT_UNPLAY, 0, nt[i], 0, 0);
				end else begin
					used[pick] = 1;
					if (ringing[pick]) add(ACT_KILL, pick, held_note[pick], 0, 0);
					ringing[pick] = 1;
					held_note[pick] = nt[i][6:0];
					add(ACT_PLAY, pick, nt[i], vl[i], nt[i] - open_note[pick]);
				end
			end
			chord_count = 0;
		endfunction

		function void take_event(logic [1:0] fn, logic [6:0] n, logic [6:0] v,
			logic [15:0] pos);
			int before_cnt;
			before_cnt = pending.size();
			if (fn == FN_NOTE_ON && v != 0) begin
				if (chord_open && pos != chord_pos) allocate_chord();
				chord_pos = pos;
				chord_open = 1;
				if (chord_count < DEPTH) begin
					chord_note[chord_count] = n;
					chord_vel[chord_count] = v;
					chord_count++;
				end else begin
					add(ACT_OVFL, 0, n, 0, 0);
				end
			end else begin
				allocate_chord();
				chord_open = 0;
				chord_pos = '0;
				if (fn == FN_NOTE_ON || fn == FN_NOTE_OFF) begin
					for (int s = 0; s < NSTR; s++) begin
						if (ringing[s] && held_note[s] == n) begin
							ringing[s] = 0;
							held_note[s] = '0;
							add(ACT_RELEASE, s, n, 0, 0);
							break;
						end
					end
				end
			end
			if (pending.size() > before_cnt) pending[$].last = 1'b1;
		endfunction

		function void check_field(string fname, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname,
					exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			check_field("action", exp_r.action, got.action);
			check_field("string_index", exp_r.str, got.str);
			check_field("note_out", exp_r.note, got.note);
			check_field("velocity_out", exp_r.vel, got.vel);
			check_field("fret", exp_r.fret, got.fret);
			check_field("last", exp_r.last, got.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  func;
	logic [6:0]  note;
	logic [6:0]  velocity;
	logic [15:0] sample_pos;
	logic        empty;
	logic        pop;
	logic [2:0]  action;
	logic [2:0]  string_index;
	logic [6:0]  note_out;
	logic [6:0]  velocity_out;
	logic [5:0]  fret;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	voicing_tracker tracker;
	int events_sent;
	int burst_left;
	int reg_errors;
	int phases;

	string_fret_voice_allocator_core i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.note(note), .velocity(velocity), .sample_pos(sample_pos), .empty(empty),
		.pop(pop), .action(action), .string_index(string_index), .note_out(note_out),
		.velocity_out(velocity_out), .fret(fret), .last(last), .psel(psel),
		.penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stall patterns, plus one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				tracker.check_result('{act_t'(action), string_index, note_out,
					velocity_out, fret, last});
			cyc++;
			if (cyc % 64 == 0) mode = $urandom_range(0, 3);
			@(negedge clk);
			if (cyc >= 2500 && cyc < 3300) pop <= 1'b0;
			else if (mode == 0) pop <= 1'b1;
			else pop <= ($urandom_range(0, mode) == 0);
		end
	end

	task automatic send_event(logic [1:0] fn, logic [6:0] n, logic [6:0] v,
		logic [15:0] pos);
		@(negedge clk);
		push <= 1'b1;
		func <= fn;
		note <= n;
		velocity <= v;
		sample_pos <= pos;
		do @(posedge clk); while (full);
		tracker.take_event(fn, n, v, pos);
		events_sent++;
		if (burst_left == 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
			burst_left = $urandom_range(0, 30);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * idx);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata != val) begin
			$display("%0t: register %0d readback, expected %0d, actual %0d", $time, idx,
				val, prdata);
			reg_errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx < NSTR) tracker.open_note[idx] = val[6:0];
		else tracker.max_fret = val[5:0];
	endtask

	task automatic set_tuning(int lo, int hi, int mf);
		for (int s = 0; s < NSTR; s++) write_reg(s, $urandom_range(lo, hi));
		write_reg(int'(REG_MAX_FRET), mf);
		phases++;
	endtask

	function automatic logic [6:0] pick_note();
		if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
		return 7'($urandom_range(tracker.open_note[0], tracker.open_note[5] + tracker.max_fret)
			& 127);
	endfunction

	task automatic random_traffic(int count);
		int k, sz;
		logic [15:0] pos;
		k = 0;
		while (k < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					pos = 16'($urandom);
					sz = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 10)
						: $urandom_range(1, 6);
					for (int i = 0; i < sz; i++) begin
						send_event(FN_NOTE_ON, pick_note(), 7'($urandom_range(1, 127)), pos);
						k++;
					end
				end
				5, 6: begin
					int s;
					s = $urandom_range(0, NSTR - 1);
					send_event($urandom_range(0, 1) ? FN_NOTE_OFF : FN_NOTE_ON,
						tracker.ringing[s] ? tracker.held_note[s] : pick_note(), '0,
						16'($urandom));
					k++;
				end
				7: begin
					send_event(FN_NOTE_OFF, pick_note(), 7'($urandom), 16'($urandom));
					k++;
				end
				default: begin
					send_event($urandom_range(0, 1) ? FN_OTHER : FN_EOB, 7'($urandom),
						7'($urandom), 16'($urandom));
					k++;
				end
			endcase
		end
	endtask

	initial begin
		tracker = new();
		events_sent = 0;
		burst_left = 0;
		reg_errors = 0;
		phases = 0;
		arst_n = 1'b0;
		push = 1'b0;
		func = '0;
		note = '0;
		velocity = '0;
		sample_pos = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// chord with lowest, highest and out-of-range notes at position zero
		send_event(FN_NOTE_ON, 7'd40, 7'd127, 16'd0);
		send_event(FN_NOTE_ON, 7'd64, 7'd1, 16'd0);
		send_event(FN_NOTE_ON, 7'd0, 7'd5, 16'd0);
		send_event(FN_NOTE_ON, 7'd127, 7'd9, 16'd0);
		// overfill a chord at the top position
		send_event(FN_NOTE_ON, 7'd60, 7'd100, 16'hffff);
		for (int i = 0; i < DEPTH; i++)
			send_event(FN_NOTE_ON, 7'(45 + 2 * i), 7'(10 + i), 16'hffff);
		send_event(FN_NOTE_OFF, 7'd60, 7'd0, 16'd3);
		send_event(FN_NOTE_ON, 7'd45, 7'd0, 16'd4);
		send_event(FN_OTHER, 7'd127, 7'd127, 16'd7);
		send_event(FN_EOB, 7'd0, 7'd0, 16'd8);
		send_event(FN_NOTE_OFF, 7'd33, 7'd0, 16'd9);
		// replay the same string to force a kill
		send_event(FN_NOTE_ON, 7'd88, 7'd64, 16'd5);
		send_event(FN_NOTE_ON, 7'd88, 7'd65, 16'd6);
		send_event(FN_EOB, 7'd0, 7'd0, 16'd0);
		drain();

		random_traffic(90);
		drain();
		set_tuning(0, 0, 63);
		random_traffic(70);
		drain();
		set_tuning(127, 127, 0);
		random_traffic(40);
		drain();
		for (int s = 0; s < NSTR; s++) write_reg(s, TUNING_RESET[s]);
		write_reg(int'(REG_MAX_FRET), 0);
		phases++;
		random_traffic(60);
		drain();
		set_tuning(20, 80, $urandom_range(1, 40));
		random_traffic(70);
		drain();
		set_tuning(30, 60, $urandom_range(5, 30));
		random_traffic(60);
		drain();

		$display("Covered %0d events and %0d results over %0d register settings.",
			events_sent, tracker.checked, phases + 1);
		if (tracker.pending.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				tracker.pending.size());
			tracker.errors++;
		end
		if (tracker.errors == 0 && reg_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
